@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clock and reset in the calling scope.
`define MMCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define MMCS_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

@@ sv/mmcs_pkg.sv @@
package mmcs_pkg;

   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HIGH = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam int DIV_STEPS  = 8;
   localparam int DIV_STEP_W = 4;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] mapped_pixel;
      logic             last_pixel;
      logic             underrun;
   } rsp_payload_type;

   typedef struct packed {
      logic               start;
      logic [2*PIX_W-1:0] dividend;
      logic [PIX_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ sv/mmcs_stream_if.sv @@
interface mmcs_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/mmcs_divider.sv @@
`include "assert_macros.svh"

module mmcs_divider
   import mmcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [PIX_W-1:0]      rem_ff, rem_in;
   logic [PIX_W-1:0]      quo_ff, quo_in;
   logic [PIX_W-1:0]      divisor_ff, divisor_in;
   logic [PIX_W:0]        trial;
   logic [PIX_W:0]        trial_diff;
   logic                  trial_ge;

   assign trial      = {rem_ff, quo_ff[PIX_W-1]};
   assign trial_ge   = trial >= {1'b0, divisor_ff};
   assign trial_diff = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = DIV_STEP_W'(DIV_STEPS);
         rem_in     = div_req.dividend[2*PIX_W-1:PIX_W];
         quo_in     = div_req.dividend[PIX_W-1:0];
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = trial_ge ? trial_diff[PIX_W-1:0] : trial[PIX_W-1:0];
         quo_in  = {quo_ff[PIX_W-2:0], trial_ge};
         step_in = step_ff - DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `MMCS_ASSERT(a_div_no_restart, div_req.start |-> !busy_ff, "divider restarted while busy")

endmodule

@@ sv/min_max_contrast_stretch.sv @@
// Stores a grayscale frame of up to MAX_PIXELS pixels, tracking its minimum and maximum, and
// returns one linearly remapped pixel for each read request. A load request gives no
// response. A read request gives one response, and the block takes no next request until
// the read is through. A read goes through the multiply, the divider load, the eight steps
// of the single restoring divider, taking the quotient and the output load, then returns to
// idle; the output load waits while the previous response has not been taken. A read that
// underruns or meets a flat frame bypasses the divider. The response register lets the next
// request be accepted while a response still waits to be taken. The frame memory needs no
// clearing after reset.
`include "assert_macros.svh"

module min_max_contrast_stretch
   import mmcs_pkg::*;
#(
   parameter int MAX_PIXELS = 16384
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_data,
   mmcs_stream_if.sink          req_if,
   mmcs_stream_if.source        rsp_if
);

   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int ADDR_W = $clog2(MAX_PIXELS);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PIXELS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_MULT   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic               shrink_ff;
   logic [PIX_W-1:0]   tlow_ff, thigh_ff;
   logic [PIX_W-1:0]   min_ff, min_in;
   logic [PIX_W-1:0]   max_ff, max_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rptr_ff, rptr_in;
   logic               closed_ff, closed_in;
   logic [PIX_W-1:0]   rd_data_ff;
   logic [2*PIX_W-1:0] num_ff, num_in;
   rsp_payload_type    result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_waddr;

   logic [PIX_W-1:0]   offset;
   logic [PIX_W-1:0]   span;
   logic               flat;
   logic               req_acc;
   logic               rsp_free;
   logic [CNT_W-1:0]   base_count;
   logic [PIX_W-1:0]   base_min;
   logic [PIX_W-1:0]   base_max;
   logic               has_room;
   logic [CNT_W-1:0]   rptr_inc;
   logic [PIX_W-1:0]   pix_clamp;
   logic [PIX_W-1:0]   pix_diff;
   logic [PIX_W:0]     quot_sum;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign offset   = shrink_ff ? tlow_ff : '0;
   assign span     = shrink_ff ? ((thigh_ff > tlow_ff) ? (thigh_ff - tlow_ff) : '0) : PIX_MAX;
   assign flat     = max_ff <= min_ff;
   assign req_acc  = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign base_count = closed_ff ? '0 : count_ff;
   assign base_min   = closed_ff ? PIX_MAX : min_ff;
   assign base_max   = closed_ff ? '0 : max_ff;
   assign has_room   = base_count < CNT_FULL;
   assign mem_waddr  = base_count[ADDR_W-1:0];
   assign rptr_inc   = rptr_ff + CNT_W'(1);

   assign pix_clamp = (rd_data_ff < min_ff) ? min_ff :
                      ((rd_data_ff > max_ff) ? max_ff : rd_data_ff);
   assign pix_diff  = pix_clamp - min_ff;
   assign quot_sum  = {1'b0, offset} + {1'b0, div_rsp.quotient};

   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      rptr_in      = rptr_ff;
      closed_in    = closed_ff;
      num_in       = num_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = num_ff;
      div_req.divisor  = max_ff - min_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_if.payload.op == OP_LOAD) begin
                  closed_in = req_if.payload.frame_end;
                  rptr_in   = closed_ff ? '0 : rptr_ff;
                  count_in  = base_count;
                  min_in    = base_min;
                  max_in    = base_max;
                  if (has_room) begin
                     mem_we   = 1'b1;
                     count_in = base_count + CNT_W'(1);
                     if (req_if.payload.pixel < base_min) begin
                        min_in = req_if.payload.pixel;
                     end
                     if (req_if.payload.pixel > base_max) begin
                        max_in = req_if.payload.pixel;
                     end
                  end
               end else if (rptr_ff == count_ff) begin
                  result_in.mapped_pixel = '0;
                  result_in.last_pixel   = 1'b0;
                  result_in.underrun     = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  mem_re  = 1'b1;
                  rptr_in = rptr_inc;
                  result_in.mapped_pixel = offset;
                  result_in.last_pixel   = rptr_inc == count_ff;
                  result_in.underrun     = 1'b0;
                  state_in = flat ? ST_FINISH : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            num_in   = {{PIX_W{1'b0}}, span} * {{PIX_W{1'b0}}, pix_diff};
            state_in = ST_MULT;
         end
         ST_MULT: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               result_in.mapped_pixel = quot_sum[PIX_W] ? PIX_MAX : quot_sum[PIX_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= PIX_MAX;
         max_ff       <= '0;
         count_ff     <= '0;
         rptr_ff      <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         rptr_ff      <= rptr_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff      <= num_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shrink_ff <= 1'b0;
         tlow_ff   <= 8'd0;
         thigh_ff  <= 8'd30;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHRINK_MODE: shrink_ff <= csr_data[0];
            CSR_TARGET_LOW:  tlow_ff   <= csr_data;
            CSR_TARGET_HIGH: thigh_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= req_if.payload.pixel;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[rptr_ff[ADDR_W-1:0]];
      end
   end

   mmcs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready   = state_ff == ST_IDLE;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   `MMCS_ASSERT(a_count_bound, count_ff <= CNT_FULL, "pixel count beyond store size")
   `MMCS_ASSERT(a_rptr_bound, rptr_ff <= count_ff, "read pointer beyond pixel count")
   `MMCS_ASSERT(a_done_in_div, div_rsp.done |-> state_ff == ST_DIV, "divider done out of step")
   `MMCS_ASSERT_NEXT(a_read_advance, req_acc && req_if.payload.op == OP_READ && rptr_ff != count_ff, rptr_ff == CNT_W'($past(rptr_ff) + 1'b1), "read did not advance pointer")

endmodule
